[rtl/alsu_pkg.sv]
`timescale 1ns / 1ps
package alsu_pkg;

  // Default list depth
  localparam int ALSU_CAPACITY = 16;

  // Stored word
  localparam int WORD_W = 32;
  typedef logic [WORD_W-1:0] word_t;

  // Request operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CHANGE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // What a cell does with its entry in the update cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_WR
  } cell_op_t;

  // Update command broadcast along the chain
  typedef struct packed {
    cell_op_t op;
    word_t    data;
  } cell_ctl_t;

  // Compare command broadcast along the chain
  typedef struct packed {
    logic  en;
    word_t key;
  } cell_cmp_t;

endpackage

[rtl/array_list_insert_delete_search_unit.sv]
`timescale 1ns / 1ps
// Channel  Direction  Fields (tdata, lowest bit first)
// in_      slave      operation, value, new_value, position
// out_     master     status, index, count
//
// Each request has an accept cycle, in which every cell compares its entry with
// the key, and an update cycle, in which the first hit is chosen and the chain
// shifts or rewrites its entries in one step.
// A finished result waits in the output register; a new request is taken
// while it waits, and the update cycle stalls until that result is taken.
// Reset (rst_n low, synchronous) empties the list; entries are not cleared.
module array_list_insert_delete_search_unit #(
  parameter int CAPACITY = alsu_pkg::ALSU_CAPACITY,
  localparam int POS_W   = $clog2(CAPACITY + 1),
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int IN_W    = ((2 + 2 * alsu_pkg::WORD_W + POS_W + 7) / 8) * 8,
  localparam int OUT_W   = ((2 + IDX_W + POS_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,  // operation, value, new_value, position
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata  // status, index, count
);
  import alsu_pkg::*;

  localparam int VAL_LO  = 2;
  localparam int NVAL_LO = VAL_LO + WORD_W;
  localparam int POS_LO  = NVAL_LO + WORD_W;
  localparam int OUT_USED = 2 + IDX_W + POS_W;
  localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  word_t            val_r, val_nxt;
  word_t            nval_r, nval_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [IDX_W-1:0] index_r, index_nxt;

  logic             in_acc;
  logic             apply_go;
  cell_ctl_t        ctl;
  cell_cmp_t        cmp;
  logic [POS_W-1:0] cell_pos;
  word_t            cell_data [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic             found;
  logic [IDX_W-1:0] first;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign apply_go  = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  // Compare the incoming key in the accept cycle
  assign cmp.en  = in_acc;
  assign cmp.key = in_tdata[VAL_LO +: WORD_W];

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    alsu_cell #(
      .POS_W(POS_W),
      .SLOT (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cmp       (cmp),
      .pos       (cell_pos),
      .count     (count_r),
      .left_data (left_w),
      .right_data(right_w),
      .data      (cell_data[g]),
      .match     (hits[g])
    );
  end

  alsu_first #(
    .N    (CAPACITY),
    .IDX_W(IDX_W)
  ) u_first (
    .hits (hits),
    .found(found),
    .first(first)
  );

  // Decide the update and the result
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    nval_nxt      = nval_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    index_nxt     = index_r;
    ctl.op        = CELL_HOLD;
    ctl.data      = val_r;
    cell_pos      = pos_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Latch a request
    if (in_acc) begin
      op_nxt    = in_tdata[1:0];
      val_nxt   = in_tdata[VAL_LO +: WORD_W];
      nval_nxt  = in_tdata[NVAL_LO +: WORD_W];
      pos_nxt   = in_tdata[POS_LO +: POS_W];
      state_nxt = S_APPLY;
    end

    // Apply it and load the result
    if (apply_go) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      index_nxt     = pos_r[IDX_W-1:0];
      case (op_r)
        OP_INSERT: begin
          if (pos_r > count_r) begin
            status_nxt = ST_BADPOS;
          end else if (count_r == CAP_COUNT) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op    = CELL_INS;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (pos_r >= count_r) begin
            status_nxt = ST_BADPOS;
          end else begin
            ctl.op    = CELL_DEL;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          index_nxt = first;
          cell_pos  = POS_W'(first);
          ctl.data  = nval_r;
          if (!found) begin
            status_nxt = ST_NOTFOUND;
          end else if (op_r == OP_CHANGE) begin
            ctl.op = CELL_WR;
          end
        end
      endcase
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    nval_r   <= nval_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - OUT_USED){1'b0}}, count_r, index_r, status_r};

endmodule

[rtl/alsu_cell.sv]
`timescale 1ns / 1ps
module alsu_cell #(
  parameter int POS_W = 5,
  parameter int SLOT  = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  alsu_pkg::cell_ctl_t ctl,
  input  alsu_pkg::cell_cmp_t cmp,
  input  logic [POS_W-1:0]  pos,
  input  logic [POS_W-1:0]  count,
  input  alsu_pkg::word_t   left_data,
  input  alsu_pkg::word_t   right_data,
  output alsu_pkg::word_t   data,
  output logic              match
);
  import alsu_pkg::*;

  localparam logic [POS_W-1:0] SLOT_POS = POS_W'(SLOT);

  word_t data_r;
  word_t data_nxt;
  logic  match_r;
  logic  match_nxt;

  // Pick the next entry: take from a neighbour on a shift, or the new word
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INS: begin
        if (SLOT_POS > pos) begin
          data_nxt = left_data;
        end else if (SLOT_POS == pos) begin
          data_nxt = ctl.data;
        end
      end
      CELL_DEL: begin
        if (SLOT_POS >= pos) begin
          data_nxt = right_data;
        end
      end
      CELL_WR: begin
        if (SLOT_POS == pos) begin
          data_nxt = ctl.data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Compare against the key; only live entries may hit
  always_comb begin
    match_nxt = match_r;
    if (cmp.en) begin
      match_nxt = (data_r == cmp.key) && (SLOT_POS < count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

[rtl/alsu_first.sv]
`timescale 1ns / 1ps
module alsu_first #(
  parameter int N    = 16,
  parameter int IDX_W = 4
) (
  input  logic [N-1:0]     hits,
  output logic             found,
  output logic [IDX_W-1:0] first
);

  // Lowest set bit wins
  always_comb begin
    first = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first = IDX_W'(i);
      end
    end
  end

  assign found = |hits;

endmodule
